/* src/lwe_dp_pkg.sv */
// Shared constants for the LWE decryption phase block.
// Used by lwe_decrypt_phase and its port checker; depends on nothing else.
package lwe_dp_pkg;

  // Width of every coefficient and result field on the stream ports
  localparam int FIELD_W = 60;
  // Input word: mask, key, body packed from bit 0, zero-padded to whole bytes
  localparam int IN_DATA_W = ((3 * FIELD_W + 7) / 8) * 8;
  // Output word: phase, inner product packed from bit 0, zero-padded to whole bytes
  localparam int OUT_DATA_W = ((2 * FIELD_W + 7) / 8) * 8;
  // Counter width for a bit walk over one field
  localparam int CNT_W = $clog2(FIELD_W);

endpackage

/* src/lwe_decrypt_phase.sv */
// LWE decryption phase: modular inner product of mask and key, then body minus it.
// Uses lwe_dp_pkg for field and port widths.
// Each word is range-checked, with any coefficient (or the accumulator) not below q
//   reduced bit-serially, then multiplied; a new word is taken only in idle, and a
//   result waiting on m_tready holds the next last word in S_PHASE; the single
//   add/compare/subtract unit is stepped through the reductions and the multiply.
// Reset (rst, synchronous, active high): modulus 2, accumulator 0, error flag clear,
//   no result pending.
module lwe_decrypt_phase #(
  parameter int MOD_BITS = 60
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration: modulus q
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lwe_dp_pkg::FIELD_W-1:0]   cfg_data,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata fields, low bit up: mask_coeff, key_coeff, body_value, zero pad
  input  logic [lwe_dp_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                             s_tlast,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata fields, low bit up: phase, inner_product
  output logic [lwe_dp_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tuser fields, low bit up: range_error
  output logic [0:0]                       m_tuser
);

  localparam int FW = lwe_dp_pkg::FIELD_W;
  localparam int CW = lwe_dp_pkg::CNT_W;
  localparam int W  = MOD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_RED, S_DBL, S_ADD, S_ACCUM, S_PHASE
  } state_t;

  typedef enum logic [1:0] {
    SEL_A, SEL_S, SEL_B, SEL_ACC
  } sel_t;

  state_t        state;
  sel_t          sel;
  logic [CW-1:0] cnt;
  logic [FW-1:0] a_r, s_r, b_r, src;
  logic          last_r;
  logic [W-1:0]  acc, r, q;
  logic          err;

  logic [FW-1:0] chk_val;
  logic [W-1:0]  opa, opb;
  logic          cin;
  logic [W:0]    sum, sum_sub;
  logic [W-1:0]  res;
  logic [W-1:0]  phase_val;
  logic [W:0]    phase_wrap;
  logic [W-1:0]  q_next;
  sel_t          sel_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);

  // clamp the written modulus to at least 2
  always_comb begin
    q_next = cfg_data[W-1:0];
    if (q_next < W'(2)) begin
      q_next = W'(2);
    end
  end

  // operand under range check
  always_comb begin
    case (sel)
      SEL_A:   chk_val = a_r;
      SEL_S:   chk_val = s_r;
      SEL_B:   chk_val = b_r;
      SEL_ACC: chk_val = FW'(acc);
      default: chk_val = a_r;
    endcase
  end

  // check order: mask, key, body only on a last word, then accumulator
  always_comb begin
    case (sel)
      SEL_A:   sel_next = SEL_S;
      SEL_S:   sel_next = last_r ? SEL_B : SEL_ACC;
      SEL_B:   sel_next = SEL_ACC;
      default: sel_next = SEL_ACC;
    endcase
  end

  // shared unit: (opa + opb + cin) reduced once by q; operands are below q
  always_comb begin
    opa = r;
    opb = r;
    cin = 1'b0;
    case (state)
      S_RED: begin
        cin = src[cnt];
      end
      S_ADD: begin
        opb = s_r[cnt] ? a_r[W-1:0] : '0;
      end
      S_ACCUM: begin
        opa = acc;
      end
      default: begin
        cin = 1'b0;
      end
    endcase
    sum     = {1'b0, opa} + {1'b0, opb} + (W + 1)'(cin);
    sum_sub = sum - {1'b0, q};
    res     = (sum >= {1'b0, q}) ? sum_sub[W-1:0] : sum[W-1:0];
  end

  // phase = (b - inner) mod q, inner held in r
  always_comb begin
    phase_wrap = {1'b0, b_r[W-1:0]} + {1'b0, q} - {1'b0, r};
    phase_val  = (b_r[W-1:0] >= r) ? (b_r[W-1:0] - r) : phase_wrap[W-1:0];
  end

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sel      <= SEL_A;
      cnt      <= '0;
      acc      <= '0;
      q        <= W'(2);
      err      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        q <= q_next;
      end

      // drop the result once taken, unless a new one loads this cycle
      if (m_tvalid && m_tready && state != S_PHASE) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            a_r    <= s_tdata[FW-1:0];
            s_r    <= s_tdata[2*FW-1:FW];
            b_r    <= s_tdata[3*FW-1:2*FW];
            last_r <= s_tlast;
            sel    <= SEL_A;
            state  <= S_CHK;
          end
        end

        S_CHK: begin
          if (chk_val >= FW'(q)) begin
            // out of range: flag coefficients, then reduce bit-serially
            if (sel != SEL_ACC) begin
              err <= 1'b1;
            end
            src   <= chk_val;
            r     <= '0;
            cnt   <= CW'(FW - 1);
            state <= S_RED;
          end else if (sel == SEL_ACC) begin
            r     <= '0;
            cnt   <= CW'(W - 1);
            state <= S_DBL;
          end else begin
            sel <= sel_next;
          end
        end

        S_RED: begin
          if (cnt == '0) begin
            case (sel)
              SEL_A:   a_r <= FW'(res);
              SEL_S:   s_r <= FW'(res);
              SEL_B:   b_r <= FW'(res);
              SEL_ACC: acc <= res;
              default: a_r <= FW'(res);
            endcase
            if (sel == SEL_ACC) begin
              r     <= '0;
              cnt   <= CW'(W - 1);
              state <= S_DBL;
            end else begin
              sel   <= sel_next;
              state <= S_CHK;
            end
          end else begin
            r   <= res;
            cnt <= cnt - CW'(1);
          end
        end

        // double-and-add multiply, key bits from the top
        S_DBL: begin
          r     <= res;
          state <= S_ADD;
        end

        S_ADD: begin
          r <= res;
          if (cnt == '0) begin
            state <= S_ACCUM;
          end else begin
            cnt   <= cnt - CW'(1);
            state <= S_DBL;
          end
        end

        S_ACCUM: begin
          if (last_r) begin
            r     <= res;
            acc   <= '0;
            state <= S_PHASE;
          end else begin
            acc   <= res;
            state <= S_IDLE;
          end
        end

        // hold until the output register is free
        S_PHASE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= lwe_dp_pkg::OUT_DATA_W'({FW'(r), FW'(phase_val)});
            m_tuser  <= err;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/lwe_dp_checker.sv */
// Port-level checker for lwe_decrypt_phase, attached by the bind below.
// Uses lwe_dp_pkg for port widths.
module lwe_dp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [lwe_dp_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [0:0]                        m_tuser
);

  logic err_reported;

  // remember that a range error has been reported since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      err_reported <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser[0]) begin
      err_reported <= 1'b1;
    end
  end

  // a word is worked through before the next: no accept on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on back-to-back cycles");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // reset leaves no result pending and the input open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

  // the range error flag stays set until reset
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && err_reported |-> m_tuser[0])
    else $error("range error flag cleared without reset");

endmodule

bind lwe_decrypt_phase lwe_dp_checker u_lwe_dp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
